// ----- src/lcgp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, payload types, state codes and helpers for the LRU cache.
package lcgp_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int REC_W   = IDX_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 7;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RANK,
    ST_INSERT,
    ST_DONE
  } state_t;

  // write port of the slot memories
  typedef struct packed {
    logic             key_en;
    logic             val_en;
    logic             rec_en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [REC_W-1:0] rec;
  } mem_wr_t;

  typedef struct packed {
    logic             key_eq;
    logic             rec_lt;
    logic [REC_W-1:0] rec_inc;
  } alu_res_t;

  // zero means one, anything above the slot count saturates
  function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    c = CMP_W'(cap);
    if (c == '0) begin
      c = CMP_W'(1);
    end else if (c > CMP_W'(ENTRIES)) begin
      c = CMP_W'(ENTRIES);
    end
    return c;
  endfunction

endpackage

// ----- src/lcgp_mem.sv -----
`timescale 1ns / 1ps
// Slot memories for key, value and recency rank, one write and one registered read port.
module lcgp_mem import lcgp_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  input  mem_wr_t          wr,
  output logic [KEY_W-1:0] rd_key,
  output logic [VAL_W-1:0] rd_val,
  output logic [REC_W-1:0] rd_rec
);

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [REC_W-1:0] rec_mem [ENTRIES];

  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [REC_W-1:0] rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      key_mem[wr.addr] <= wr.key;
    end
    rd_key_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.val_en) begin
      val_mem[wr.addr] <= wr.val;
    end
    rd_val_r <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.rec_en) begin
      rec_mem[wr.addr] <= wr.rec;
    end
    rd_rec_r <= rec_mem[rd_addr];
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;
  assign rd_rec = rd_rec_r;

endmodule

// ----- src/lcgp_alu.sv -----
`timescale 1ns / 1ps
// Shared slot unit: key match, rank compare and rank increment for both passes.
module lcgp_alu import lcgp_pkg::*; (
  input  logic [KEY_W-1:0] key_a,
  input  logic [KEY_W-1:0] key_b,
  input  logic [REC_W-1:0] rec_a,
  input  logic [REC_W-1:0] rec_b,
  input  logic [REC_W-1:0] rec_src,
  output alu_res_t         res
);

  always_comb begin
    res.key_eq  = (key_a == key_b);
    res.rec_lt  = (rec_a < rec_b);
    res.rec_inc = rec_src + REC_W'(1);
  end

endmodule

// ----- src/lcgp_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: match scan, eviction choice, rank update pass and insertion.
module lcgp_seq import lcgp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_t              in_item,
  input  logic [CMP_W-1:0] cap_eff,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output out_t             res_data,
  output logic [IDX_W-1:0] rd_addr,
  output mem_wr_t          wr,
  input  logic [KEY_W-1:0] rd_key,
  input  logic [VAL_W-1:0] rd_val,
  input  logic [REC_W-1:0] rd_rec
);

  state_t state_r, state_nxt;

  in_t              item_r;
  logic [CNT_W-1:0] cnt_r;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0] used_r;

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [REC_W-1:0] hit_rec_r;
  logic [VAL_W-1:0] hit_val_r;

  logic             vic_any_r;
  logic [IDX_W-1:0] vic_idx_r;
  logic [REC_W-1:0] vic_rec_r;
  logic [KEY_W-1:0] vic_key_r;

  logic             free_any_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [IDX_W-1:0] new_idx_r;
  out_t             res_r;

  logic             issue;
  logic             pass_end;
  logic             valid_at;
  logic             is_put;
  logic             evict_c;
  logic             have_free_c;
  logic [IDX_W-1:0] new_idx_c;
  logic [REC_W-1:0] rec_a;
  logic [REC_W-1:0] rec_b;
  alu_res_t         alu;

  assign issue    = ((state_r == ST_SCAN) || (state_r == ST_RANK)) &&
                    (cnt_r < CNT_W'(ENTRIES));
  assign pass_end = chk_v_r && (chk_idx_r == IDX_W'(ENTRIES - 1));
  assign valid_at = valid_r[chk_idx_r];
  assign is_put   = (item_r.operation == OP_PUT);

  // scan: victim search keeps the oldest rank; rank pass: age entries newer than the hit
  assign rec_a = (state_r == ST_SCAN) ? vic_rec_r : rd_rec;
  assign rec_b = (state_r == ST_SCAN) ? rd_rec : hit_rec_r;

  lcgp_alu u_alu (
    .key_a   (rd_key),
    .key_b   (item_r.lookup_key),
    .rec_a   (rec_a),
    .rec_b   (rec_b),
    .rec_src (rd_rec),
    .res     (alu)
  );

  always_comb begin
    evict_c = !hit_r && is_put && vic_any_r && (used_r != '0) &&
              (CMP_W'(used_r) >= cap_eff);
    have_free_c = evict_c || free_any_r;
    if (evict_c) begin
      new_idx_c = (free_any_r && (free_idx_r < vic_idx_r)) ? free_idx_r : vic_idx_r;
    end else begin
      new_idx_c = free_idx_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass_end) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_r || (is_put && have_free_c)) begin
          state_nxt = ST_RANK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RANK: begin
        if (pass_end) begin
          state_nxt = hit_r ? ST_DONE : ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and memory port
  always_comb begin
    idle      = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    res_data  = res_r;
    rd_addr   = cnt_r[IDX_W-1:0];
    wr        = '0;
    case (state_r)
      ST_DECIDE: begin
        if (hit_r && is_put) begin
          wr.val_en = 1'b1;
          wr.addr   = hit_idx_r;
          wr.val    = item_r.write_value;
        end
      end
      ST_RANK: begin
        wr.addr = chk_idx_r;
        if (chk_v_r) begin
          if (hit_r) begin
            if (chk_idx_r == hit_idx_r) begin
              wr.rec_en = 1'b1;
              wr.rec    = '0;
            end else if (valid_at && alu.rec_lt) begin
              wr.rec_en = 1'b1;
              wr.rec    = alu.rec_inc;
            end
          end else if (valid_at) begin
            wr.rec_en = 1'b1;
            wr.rec    = alu.rec_inc;
          end
        end
      end
      ST_INSERT: begin
        wr.key_en = 1'b1;
        wr.val_en = 1'b1;
        wr.rec_en = 1'b1;
        wr.addr   = new_idx_r;
        wr.key    = item_r.lookup_key;
        wr.val    = item_r.write_value;
        wr.rec    = '0;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chk_v_r <= 1'b0;
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= issue;
      if ((state_r == ST_DECIDE) && evict_c) begin
        valid_r[vic_idx_r] <= 1'b0;
        used_r             <= used_r - CNT_W'(1);
      end
      if (state_r == ST_INSERT) begin
        valid_r[new_idx_r] <= 1'b1;
        used_r             <= used_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= rd_addr;
    if (issue) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (start) begin
      item_r     <= in_item;
      cnt_r      <= '0;
      hit_r      <= 1'b0;
      vic_any_r  <= 1'b0;
      free_any_r <= 1'b0;
    end
    if ((state_r == ST_SCAN) && chk_v_r) begin
      // first match wins, lowest free slot wins
      if (valid_at && alu.key_eq && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= chk_idx_r;
        hit_rec_r <= rd_rec;
        hit_val_r <= rd_val;
      end
      if (valid_at && (!vic_any_r || alu.rec_lt)) begin
        vic_any_r <= 1'b1;
        vic_idx_r <= chk_idx_r;
        vic_rec_r <= rd_rec;
        vic_key_r <= rd_key;
      end
      if (!valid_at && !free_any_r) begin
        free_any_r <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
    end
    if (state_r == ST_DECIDE) begin
      cnt_r             <= '0;
      new_idx_r         <= new_idx_c;
      res_r.found       <= hit_r;
      res_r.read_value  <= (hit_r && !is_put) ? hit_val_r : MISS_VALUE;
      res_r.evicted     <= evict_c;
      res_r.evicted_key <= evict_c ? vic_key_r : '0;
    end
  end

endmodule

// ----- src/lru_cache_get_put.sv -----
`timescale 1ns / 1ps
// Top level of the fully associative LRU key-value cache.
//
//  channel  direction  handshake              word
//  in_      input      in_valid / in_ready    in_t: operation, lookup_key, write_value
//  out_     output     out_valid / out_ready  out_t: found, read_value, evicted, evicted_key
//  cfg_     input      cfg_valid / cfg_ready  capacity, 7 bits
//
// A word runs a match scan and then, when it hits or inserts, a rank update pass; a get
// miss skips the rank pass. Both passes are paced by the single read port of the slot
// memories: one slot per cycle in the match scan and again in the rank update pass.
// No new word is taken while one is at work.
// Reset is synchronous and active low; it clears all valid bits at once, no sweep.
// A result waiting on out_ready does not block the next input word.
module lru_cache_get_put import lcgp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             seq_idle;
  logic             res_valid;
  logic             res_take;
  out_t             res_data;
  logic [IDX_W-1:0] rd_addr;
  mem_wr_t          wr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [REC_W-1:0] rd_rec;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle;
  assign res_take  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (res_valid && res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res_data;
    end
  end

  lcgp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .in_item   (in_data),
    .cap_eff   (eff_cap(cap_r)),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .rd_key    (rd_key),
    .rd_val    (rd_val),
    .rd_rec    (rd_rec)
  );

  lcgp_mem u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_key  (rd_key),
    .rd_val  (rd_val),
    .rd_rec  (rd_rec)
  );

endmodule

// ----- src/lcgp_chk.sv -----
`timescale 1ns / 1ps
// Port checker for the LRU cache and its bind to the top level.
module lcgp_chk import lcgp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  // an accepted word keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after acceptance");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.read_value == MISS_VALUE)
    else $error("miss did not return minus one");

  a_no_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |-> out_data.evicted_key == '0)
    else $error("evicted key set without an eviction");

  // only an absent key can cause an eviction
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> !out_data.found)
    else $error("eviction reported on a hit");

endmodule

bind lru_cache_get_put lcgp_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
